// ===== src/omcs_pkg.sv =====
// shared types and constants for the one-memory count sketch
// no dependencies; imported by every module of the block except omcs_ram
`default_nettype none

package omcs_pkg;

    // input field layout
    localparam int WIDX_BITS     = 12;
    localparam int SLOT_BITS     = 3;
    localparam int CMD_BITS      = 2;
    localparam int WORDS_IN_BITS = 24;
    localparam int SLOTS_IN_BITS = 12;
    localparam int SIGNS_IN_BITS = 4;

    // result field widths
    localparam int EST_BITS  = 17;
    localparam int DCNT_BITS = 3;

    // word index reducer: bits retired per cycle and steps per index
    localparam int MOD_STEP_BITS = 4;
    localparam int MOD_STEPS     = WIDX_BITS / MOD_STEP_BITS;

    // command codes
    localparam logic [CMD_BITS-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_BITS-1:0] CMD_DELETE = 2'd1;
    localparam logic [CMD_BITS-1:0] CMD_QUERY  = 2'd2;
    localparam logic [CMD_BITS-1:0] CMD_NONE   = 2'd3;

    // sequencer states
    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH_START,
        S_HASH_WAIT,
        S_ROW,
        S_UPD,
        S_SHIFT,
        S_DONE
    } t_state;

    // controls from the sequencer to the median unit
    typedef struct packed {
        logic ins;
        logic shift;
    } t_med_ctl;

endpackage

`default_nettype wire

// ===== src/omcs_ram.sv =====
// generic single-port-write, single-port-read ram with registered read data
// no dependencies
`default_nettype none

module omcs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32768
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== src/omcs_wred.sv =====
// iterative word index reducer: index modulo WORD_COUNT, MOD_STEP_BITS bits per cycle
// depends on omcs_pkg
`default_nettype none

module omcs_wred import omcs_pkg::*; #(
    parameter int WORD_COUNT = 4096
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_start,
    input  wire logic [WIDX_BITS-1:0] i_value,
    output logic                      o_done,
    output logic      [WIDX_BITS-1:0] o_rem
);

    // partial remainders never exceed the index itself, so a clamped limit suffices
    localparam int LIM_INT = (WORD_COUNT > 8191) ? 8191 : WORD_COUNT;
    localparam logic [WIDX_BITS:0] LIM = (WIDX_BITS + 1)'(LIM_INT);
    localparam int CNT_BITS = (MOD_STEPS > 1) ? $clog2(MOD_STEPS) : 1;
    localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(MOD_STEPS - 1);

    logic                 r_busy;
    logic                 r_done;
    logic [CNT_BITS-1:0]  r_cnt;
    logic [WIDX_BITS-1:0] r_val;
    logic [WIDX_BITS-1:0] r_rem;
    logic [WIDX_BITS-1:0] n_val;
    logic [WIDX_BITS-1:0] n_rem;
    logic [WIDX_BITS:0]   t;

    // restoring remainder over the next group of index bits, msb first
    always_comb begin
        t     = '0;
        n_rem = r_rem;
        n_val = r_val;
        for (int k = 0; k < MOD_STEP_BITS; k++) begin
            t = {n_rem, n_val[WIDX_BITS-1]};
            if (t >= LIM) begin
                t = t - LIM;
            end
            n_rem = t[WIDX_BITS-1:0];
            n_val = {n_val[WIDX_BITS-2:0], 1'b0};
        end
    end

    // step counter and done pulse
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // working value and remainder
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_val <= i_value;
            r_rem <= '0;
        end else if (r_busy) begin
            r_val <= n_val;
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

`default_nettype wire

// ===== src/omcs_median.sv =====
// sorted reading list with insert and shift-down, and the median estimate
// depends on omcs_pkg
`default_nettype none

module omcs_median import omcs_pkg::*; #(
    parameter int ROWS     = 4,
    parameter int KEY_BITS = 17
) (
    input  wire logic                        i_clk,
    input  wire t_med_ctl                    i_ctl,
    input  wire logic signed [KEY_BITS-1:0]  i_key,
    input  wire logic [$clog2(ROWS+1)-1:0]   i_count,
    output logic signed      [EST_BITS-1:0]  o_estimate
);

    localparam int SN  = (ROWS < 2) ? 2 : ROWS;
    localparam int EXT = (KEY_BITS > EST_BITS) ? KEY_BITS : EST_BITS;

    logic signed [KEY_BITS-1:0] r_sorted [SN];
    logic signed [KEY_BITS-1:0] n_ins    [SN];
    logic                       gt       [SN];
    logic        [KEY_BITS-1:0] abs_lo;
    logic        [KEY_BITS-1:0] abs_hi;
    logic        [KEY_BITS:0]   abs_sum;
    logic signed [EXT-1:0]      est_ext;

    // parallel insert of the new reading into the ascending list
    always_comb begin
        for (int k = 0; k < SN; k++) begin
            gt[k] = (k < int'(i_count)) && (r_sorted[k] > i_key);
        end
        for (int k = 0; k < SN; k++) begin
            if ((k == int'(i_count)) || gt[k]) begin
                if (k == 0) begin
                    n_ins[k] = i_key;
                end else if (gt[k-1]) begin
                    n_ins[k] = r_sorted[k-1];
                end else begin
                    n_ins[k] = i_key;
                end
            end else begin
                n_ins[k] = r_sorted[k];
            end
        end
    end

    // list update: insert, or move every entry one place toward the head
    always_ff @(posedge i_clk) begin
        if (i_ctl.ins) begin
            for (int k = 0; k < SN; k++) begin
                r_sorted[k] <= n_ins[k];
            end
        end else if (i_ctl.shift) begin
            for (int k = 0; k < SN - 1; k++) begin
                r_sorted[k] <= r_sorted[k+1];
            end
        end
    end

    // middle reading for an odd count, halved sum of magnitudes for an even one
    always_comb begin
        abs_lo  = r_sorted[0][KEY_BITS-1] ? KEY_BITS'(-r_sorted[0]) : r_sorted[0];
        abs_hi  = r_sorted[1][KEY_BITS-1] ? KEY_BITS'(-r_sorted[1]) : r_sorted[1];
        abs_sum = {1'b0, abs_lo} + {1'b0, abs_hi};
        if (i_count[0]) begin
            est_ext = EXT'(r_sorted[0]);
        end else begin
            est_ext = signed'(EXT'(abs_sum[KEY_BITS:1]));
        end
    end

    assign o_estimate = est_ext[EST_BITS-1:0];

endmodule

`default_nettype wire

// ===== src/one_memory_count_sketch.sv =====
// one-memory count sketch: top level with sequencer, counter ram and median unit
// depends on omcs_pkg, omcs_ram, omcs_wred, omcs_median
//
// Usage
// - input channel i_in_valid / o_in_ready carries cmd, word_indices, counter_slots
//   and sign_bits; a transfer happens when both are high at a clock edge
// - insert and delete update the counters and give no result; command three is
//   taken and dropped; a query gives one result on o_out_valid / i_out_ready
// - after reset the counter ram is swept to zero, one counter a cycle, over all
//   WORD_COUNT * COUNTERS_PER_WORD counters (32768 by default); o_in_ready stays low
// - one item at a time: word indices are reduced by a shared 4-bit-per-cycle unit
//   one word hash after another, then each row goes through S_ROW and S_UPD on the
//   counter ram (read, then update or read-out); a row that repeats a cell skips S_UPD
// - a query then shifts the sorted list down to the middle reading in S_SHIFT and
//   hands the estimate over in S_DONE
// - the result sits in an output register; the next item is taken while it waits,
//   and a later query holds in its final step until that register is free
//
`default_nettype none

module one_memory_count_sketch import omcs_pkg::*; #(
    parameter int WORD_COUNT        = 4096,
    parameter int COUNTERS_PER_WORD = 8,
    parameter int WORD_HASHES       = 2,
    parameter int COUNTER_ROWS      = 4,
    parameter int COUNTER_BITS      = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_in_valid,
    output logic                          o_in_ready,
    input  wire logic [CMD_BITS-1:0]      i_cmd,
    input  wire logic [WORDS_IN_BITS-1:0] i_word_indices,
    input  wire logic [SLOTS_IN_BITS-1:0] i_counter_slots,
    input  wire logic [SIGNS_IN_BITS-1:0] i_sign_bits,
    output logic                          o_out_valid,
    input  wire logic                     i_out_ready,
    output logic signed [EST_BITS-1:0]    o_estimate,
    output logic [DCNT_BITS-1:0]          o_distinct_cells
);

    localparam int CELLS     = WORD_COUNT * COUNTERS_PER_WORD;
    localparam int CB        = $clog2(CELLS);
    localparam int WB        = $clog2(WORD_COUNT);
    localparam int SB        = $clog2(COUNTERS_PER_WORD);
    localparam int HB        = (WORD_HASHES > 1) ? $clog2(WORD_HASHES) : 1;
    localparam int RWB       = (COUNTER_ROWS > 1) ? $clog2(COUNTER_ROWS) : 1;
    localparam int NB        = $clog2(COUNTER_ROWS + 1);
    localparam int KB        = COUNTER_BITS + 1;
    localparam int WORDS_EXT = WORD_HASHES * WIDX_BITS;
    localparam int SLOTS_EXT = COUNTER_ROWS * SLOT_BITS;
    localparam int SLIM_INT  = (COUNTERS_PER_WORD > 8) ? 8 : COUNTERS_PER_WORD;

    localparam logic [CB-1:0]           CELL_LAST = CB'(CELLS - 1);
    localparam logic [CB-1:0]           CPW_C     = CB'(COUNTERS_PER_WORD);
    localparam logic [HB-1:0]           HASH_LAST = HB'(WORD_HASHES - 1);
    localparam logic [RWB-1:0]          ROW_LAST  = RWB'(COUNTER_ROWS - 1);
    localparam logic [SLOT_BITS:0]      SLIM      = (SLOT_BITS + 1)'(SLIM_INT);
    localparam logic [NB-1:0]           N_ONE     = NB'(1);
    localparam logic signed [COUNTER_BITS-1:0] CMAX  = {1'b0, {(COUNTER_BITS-1){1'b1}}};
    localparam logic signed [COUNTER_BITS-1:0] CMIN  = {1'b1, {(COUNTER_BITS-1){1'b0}}};
    localparam logic signed [COUNTER_BITS-1:0] C_ONE = COUNTER_BITS'(1);

    // control registers
    t_state         r_state, n_state;
    logic [CB-1:0]  r_clr, n_clr;
    logic [HB-1:0]  r_hash, n_hash;
    logic [HB-1:0]  r_hsel, n_hsel;
    logic [RWB-1:0] r_row, n_row;
    logic [NB-1:0]  r_n, n_n;
    logic [NB-1:0]  r_shift, n_shift;
    logic           r_out_valid, n_out_valid;

    // payload registers
    logic [CMD_BITS-1:0]        r_cmd, n_cmd;
    logic [WORDS_EXT-1:0]       r_words, n_words;
    logic [SLOTS_EXT-1:0]       r_slots, n_slots;
    logic [COUNTER_ROWS-1:0]    r_signs, n_signs;
    logic [CB-1:0]              r_cell, n_cell;
    logic signed [EST_BITS-1:0] r_est, n_est;
    logic [DCNT_BITS-1:0]       r_dcnt, n_dcnt;
    logic [CB-1:0]              r_used [COUNTER_ROWS];
    logic [WB-1:0]              r_wmod [WORD_HASHES];

    // datapath
    logic                       red_start;
    logic                       red_done;
    logic [WIDX_BITS-1:0]       red_rem;
    logic                       wmod_we;
    logic                       used_we;
    logic [WB-1:0]              wsel;
    logic [SLOT_BITS-1:0]       slot_raw;
    logic [SLOT_BITS-1:0]       srem;
    logic [SLOT_BITS:0]         st;
    logic [SB-1:0]              smod;
    logic [CB-1:0]              cell_addr;
    logic                       seen;
    logic                       last_row;
    logic                       is_update;
    logic                       dec;
    logic                       row_sign;
    logic signed [COUNTER_BITS-1:0] v;
    logic signed [COUNTER_BITS-1:0] upd_val;
    logic                       at_lim;
    logic signed [KB-1:0]       vx;
    logic signed [KB-1:0]       key;
    logic [NB-1:0]              n_minus;
    logic [NB-1:0]              shift_need;
    logic                       ram_we;
    logic [CB-1:0]              ram_waddr;
    logic [COUNTER_BITS-1:0]    ram_wdata;
    logic [COUNTER_BITS-1:0]    ram_rdata;
    t_med_ctl                   med_ctl;
    logic signed [EST_BITS-1:0] med_est;

    // shared word index reducer
    omcs_wred #(
        .WORD_COUNT (WORD_COUNT)
    ) u_wred (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (red_start),
        .i_value (r_words[r_hash*WIDX_BITS +: WIDX_BITS]),
        .o_done  (red_done),
        .o_rem   (red_rem)
    );

    // counter store
    omcs_ram #(
        .WIDTH (COUNTER_BITS),
        .DEPTH (CELLS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (cell_addr),
        .o_rdata (ram_rdata)
    );

    // sorted readings and estimate
    omcs_median #(
        .ROWS     (COUNTER_ROWS),
        .KEY_BITS (KB)
    ) u_median (
        .i_clk      (i_clk),
        .i_ctl      (med_ctl),
        .i_key      (key),
        .i_count    (r_n),
        .o_estimate (med_est)
    );

    // reduced word index of the current row's hash
    always_comb begin
        wsel = '0;
        for (int h = 0; h < WORD_HASHES; h++) begin
            if (r_hsel == HB'(h)) begin
                wsel = r_wmod[h];
            end
        end
    end

    // slot modulo counters per word, one compare and subtract per slot bit
    always_comb begin
        slot_raw = r_slots[r_row*SLOT_BITS +: SLOT_BITS];
        srem     = '0;
        st       = '0;
        for (int k = SLOT_BITS - 1; k >= 0; k--) begin
            st = {srem, slot_raw[k]};
            if (st >= SLIM) begin
                st = st - SLIM;
            end
            srem = st[SLOT_BITS-1:0];
        end
        smod = SB'(srem);
    end

    // cell address and repeat check against earlier rows of this item
    always_comb begin
        cell_addr = CB'(wsel) * CPW_C + CB'(smod);
        seen = 1'b0;
        for (int j = 0; j < COUNTER_ROWS; j++) begin
            if ((j < int'(r_n)) && (r_used[j] == cell_addr)) begin
                seen = 1'b1;
            end
        end
    end

    // saturating update and signed reading of the fetched counter
    always_comb begin
        v         = signed'(ram_rdata);
        row_sign  = r_signs[r_row];
        is_update = (r_cmd == CMD_INSERT) || (r_cmd == CMD_DELETE);
        dec       = row_sign ^ (r_cmd == CMD_DELETE);
        at_lim    = dec ? (v == CMIN) : (v == CMAX);
        upd_val   = dec ? (v - C_ONE) : (v + C_ONE);
        vx        = KB'(v);
        key       = row_sign ? -vx : vx;
        last_row  = (r_row == ROW_LAST);
        n_minus   = r_n - N_ONE;
        shift_need = n_minus >> 1;
    end

    // sequencer: next state and strobes
    always_comb begin
        n_state     = r_state;
        n_clr       = r_clr;
        n_hash      = r_hash;
        n_hsel      = r_hsel;
        n_row       = r_row;
        n_n         = r_n;
        n_shift     = r_shift;
        n_out_valid = r_out_valid & ~i_out_ready;
        n_cmd       = r_cmd;
        n_words     = r_words;
        n_slots     = r_slots;
        n_signs     = r_signs;
        n_cell      = r_cell;
        n_est       = r_est;
        n_dcnt      = r_dcnt;
        red_start   = 1'b0;
        wmod_we     = 1'b0;
        used_we     = 1'b0;
        ram_we      = 1'b0;
        ram_waddr   = r_cell;
        ram_wdata   = upd_val;
        med_ctl     = '0;
        o_in_ready  = 1'b0;

        case (r_state)
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr;
                ram_wdata = '0;
                if (r_clr == CELL_LAST) begin
                    n_state = S_IDLE;
                end else begin
                    n_clr = r_clr + 1'b1;
                end
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_cmd   = i_cmd;
                    n_words = WORDS_EXT'(i_word_indices);
                    n_slots = SLOTS_EXT'(i_counter_slots);
                    n_signs = COUNTER_ROWS'(i_sign_bits);
                    n_hash  = '0;
                    n_hsel  = '0;
                    n_row   = '0;
                    n_n     = '0;
                    n_shift = '0;
                    if (i_cmd != CMD_NONE) begin
                        n_state = S_HASH_START;
                    end
                end
            end
            S_HASH_START: begin
                red_start = 1'b1;
                n_state   = S_HASH_WAIT;
            end
            S_HASH_WAIT: begin
                if (red_done) begin
                    wmod_we = 1'b1;
                    if (r_hash == HASH_LAST) begin
                        n_state = S_ROW;
                    end else begin
                        n_hash  = r_hash + 1'b1;
                        n_state = S_HASH_START;
                    end
                end
            end
            S_ROW: begin
                if (seen) begin
                    if (last_row) begin
                        n_state = (r_cmd == CMD_QUERY) ? S_SHIFT : S_IDLE;
                    end else begin
                        n_row  = r_row + 1'b1;
                        n_hsel = (r_hsel == HASH_LAST) ? '0 : r_hsel + 1'b1;
                    end
                end else begin
                    used_we = 1'b1;
                    n_cell  = cell_addr;
                    n_state = S_UPD;
                end
            end
            S_UPD: begin
                if (is_update) begin
                    ram_we = ~at_lim;
                end else begin
                    med_ctl.ins = 1'b1;
                end
                n_n = r_n + 1'b1;
                if (last_row) begin
                    n_state = (r_cmd == CMD_QUERY) ? S_SHIFT : S_IDLE;
                end else begin
                    n_row   = r_row + 1'b1;
                    n_hsel  = (r_hsel == HASH_LAST) ? '0 : r_hsel + 1'b1;
                    n_state = S_ROW;
                end
            end
            S_SHIFT: begin
                if (r_shift == shift_need) begin
                    n_state = S_DONE;
                end else begin
                    med_ctl.shift = 1'b1;
                    n_shift       = r_shift + 1'b1;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_est       = med_est;
                    n_dcnt      = DCNT_BITS'(r_n);
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_hash      <= '0;
            r_hsel      <= '0;
            r_row       <= '0;
            r_n         <= '0;
            r_shift     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_hash      <= n_hash;
            r_hsel      <= n_hsel;
            r_row       <= n_row;
            r_n         <= n_n;
            r_shift     <= n_shift;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_cmd   <= n_cmd;
        r_words <= n_words;
        r_slots <= n_slots;
        r_signs <= n_signs;
        r_cell  <= n_cell;
        r_est   <= n_est;
        r_dcnt  <= n_dcnt;
        for (int h = 0; h < WORD_HASHES; h++) begin
            if (wmod_we && (r_hash == HB'(h))) begin
                r_wmod[h] <= WB'(red_rem);
            end
        end
        for (int j = 0; j < COUNTER_ROWS; j++) begin
            if (used_we && (int'(r_n) == j)) begin
                r_used[j] <= cell_addr;
            end
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_estimate       = r_est;
    assign o_distinct_cells = r_dcnt;

endmodule

`default_nettype wire
